FILE: src/rid_pkg.sv
// Package for the instruction decoder: mnemonic and operand form codes,
// instruction field codes and the decoded result record.
// No dependencies.
package rid_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned MN_W   = 6;
	localparam int unsigned FORM_W = 4;
	localparam int unsigned REG_W  = 5;
	localparam int unsigned IMM_W  = 16;

	localparam logic [1:0] CLS_MEM   = 2'd0;
	localparam logic [1:0] CLS_ARITH = 2'd1;
	localparam logic [1:0] CLS_FLOAT = 2'd2;
	localparam logic [1:0] CLS_MISC  = 2'd3;

	localparam logic [3:0] OP_BR_LAST = 4'h3;
	localparam logic [3:0] OP_BB_LAST = 4'h7;
	localparam logic [3:0] OP_BCND    = 4'ha;
	localparam logic [3:0] OP_BCND_N  = 4'hb;
	localparam logic [3:0] OP_BITFLD  = 4'hc;
	localparam logic [3:0] OP_REG     = 4'hd;
	localparam logic [3:0] OP_TBND    = 4'he;

	localparam logic [5:0] SUB_CLR  = 6'h20;
	localparam logic [5:0] SUB_SET  = 6'h22;
	localparam logic [5:0] SUB_EXT  = 6'h24;
	localparam logic [5:0] SUB_EXTU = 6'h26;
	localparam logic [5:0] SUB_MAK  = 6'h28;
	localparam logic [5:0] SUB_ROT  = 6'h2a;
	localparam logic [5:0] SUB_TB0  = 6'h34;
	localparam logic [5:0] SUB_TB1  = 6'h36;
	localparam logic [5:0] SUB_TCND = 6'h3a;

	localparam logic [1:0] RSEL_MEM   = 2'd0;
	localparam logic [1:0] RSEL_ARITH = 2'd1;
	localparam logic [1:0] RSEL_BITFLD = 2'd2;
	localparam logic [1:0] RSEL_CTRL  = 2'd3;

	localparam logic [2:0] RBF_LAST   = 3'd5;
	localparam logic [3:0] CTRL_JMP_LAST = 4'h3;
	localparam logic [3:0] CTRL_FF1   = 4'ha;
	localparam logic [3:0] CTRL_FF0   = 4'hb;
	localparam logic [3:0] CTRL_TBND  = 4'he;
	localparam logic [3:0] CTRL_RTE   = 4'hf;

	localparam logic [MN_W-1:0] MN_XMEM_BU = 6'd0;
	localparam logic [MN_W-1:0] MN_AND     = 6'd16;
	localparam logic [MN_W-1:0] MN_BR      = 6'd32;
	localparam logic [MN_W-1:0] MN_BB0     = 6'd36;
	localparam logic [MN_W-1:0] MN_BCND    = 6'd40;
	localparam logic [MN_W-1:0] MN_CLR     = 6'd42;
	localparam logic [MN_W-1:0] MN_SET     = 6'd43;
	localparam logic [MN_W-1:0] MN_EXT     = 6'd44;
	localparam logic [MN_W-1:0] MN_EXTU    = 6'd45;
	localparam logic [MN_W-1:0] MN_MAK     = 6'd46;
	localparam logic [MN_W-1:0] MN_ROT     = 6'd47;
	localparam logic [MN_W-1:0] MN_TB0     = 6'd48;
	localparam logic [MN_W-1:0] MN_TB1     = 6'd49;
	localparam logic [MN_W-1:0] MN_TCND    = 6'd50;
	localparam logic [MN_W-1:0] MN_TBND    = 6'd51;
	localparam logic [MN_W-1:0] MN_JMP     = 6'd52;
	localparam logic [MN_W-1:0] MN_FF1     = 6'd56;
	localparam logic [MN_W-1:0] MN_RTE     = 6'd58;
	localparam logic [MN_W-1:0] MN_FLOAT   = 6'd59;
	localparam logic [MN_W-1:0] MN_ILLEGAL = 6'd60;

	localparam logic [FORM_W-1:0] FORM_RRI     = 4'd0;
	localparam logic [FORM_W-1:0] FORM_RRR     = 4'd1;
	localparam logic [FORM_W-1:0] FORM_BRANCH  = 4'd2;
	localparam logic [FORM_W-1:0] FORM_BITBR   = 4'd3;
	localparam logic [FORM_W-1:0] FORM_BITFLD  = 4'd4;
	localparam logic [FORM_W-1:0] FORM_TRAP    = 4'd5;
	localparam logic [FORM_W-1:0] FORM_ONEREG  = 4'd6;
	localparam logic [FORM_W-1:0] FORM_NONE    = 4'd7;
	localparam logic [FORM_W-1:0] FORM_FLOAT   = 4'd8;
	localparam logic [FORM_W-1:0] FORM_ILLEGAL = 4'd9;

	typedef struct packed {
		logic [MN_W-1:0]   mnemonic;
		logic [FORM_W-1:0] form;
		logic [REG_W-1:0]  dest_reg;
		logic [REG_W-1:0]  src1_reg;
		logic [REG_W-1:0]  src2_reg;
		logic [IMM_W-1:0]  immediate;
		logic [REG_W-1:0]  cond_or_bit;
		logic [WORD_W-1:0] target;
		logic [1:0]        carry_suffix;
		logic              scaled;
	} rid_result_t;

endpackage

FILE: src/risc_instruction_decoder.sv
// Instruction decoder top level: input register, decode logic, result register.
// Depends on rid_pkg.
//
//   channel   direction  handshake           payload
//   input     in         in_valid/in_stall   instr_word, pc
//   result    out        out_valid/out_stall mnemonic .. scaled
//
// An input transaction passes the input register, then the result register;
// the decode and the branch target add sit between. One transaction per cycle
// sustained while out_stall is low. Reset clears both valid flags only.
// in_stall rises only while both registers are full and out_stall is high.
module risc_instruction_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [rid_pkg::WORD_W-1:0]     instr_word,
	input  logic [rid_pkg::WORD_W-1:0]     pc,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [rid_pkg::MN_W-1:0]       mnemonic,
	output logic [rid_pkg::FORM_W-1:0]     form,
	output logic [rid_pkg::REG_W-1:0]      dest_reg,
	output logic [rid_pkg::REG_W-1:0]      src1_reg,
	output logic [rid_pkg::REG_W-1:0]      src2_reg,
	output logic [rid_pkg::IMM_W-1:0]      immediate,
	output logic [rid_pkg::REG_W-1:0]      cond_or_bit,
	output logic [rid_pkg::WORD_W-1:0]     target,
	output logic [1:0]                     carry_suffix,
	output logic                           scaled
);
	import rid_pkg::*;

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic [WORD_W-1:0] pc_s1;
	logic              valid_s2;
	rid_result_t       res_s2;
	rid_result_t       dec;
	logic              hold_s2;

	logic [1:0]  cls;
	logic [3:0]  op;
	logic [5:0]  bsub;
	logic [1:0]  rsel;
	logic [3:0]  rsub;
	logic [2:0]  rbf;
	logic [4:0]  rd;
	logic [4:0]  rs1;
	logic [4:0]  rs2;
	logic [WORD_W-1:0] off26;
	logic [WORD_W-1:0] off16;

	assign hold_s2  = valid_s2 && out_stall;
	assign in_stall = valid_s1 && hold_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= instr_word;
			pc_s1   <= pc;
		end
	end

	assign cls  = word_s1[31:30];
	assign op   = word_s1[29:26];
	assign bsub = word_s1[15:10];
	assign rsel = word_s1[15:14];
	assign rsub = word_s1[13:10];
	assign rbf  = word_s1[13:11];
	assign rd   = word_s1[25:21];
	assign rs1  = word_s1[20:16];
	assign rs2  = word_s1[4:0];
	assign off26 = {{4{word_s1[25]}}, word_s1[25:0], 2'b00};
	assign off16 = {{14{word_s1[15]}}, word_s1[15:0], 2'b00};

	always_comb begin
		dec = '0;
		dec.mnemonic = MN_ILLEGAL;
		dec.form     = FORM_ILLEGAL;
		case (cls)
			CLS_MEM, CLS_ARITH: begin
				dec.mnemonic  = ((cls == CLS_MEM) ? MN_XMEM_BU : MN_AND) + {2'b00, op};
				dec.form      = FORM_RRI;
				dec.dest_reg  = rd;
				dec.src1_reg  = rs1;
				dec.immediate = word_s1[15:0];
			end
			CLS_FLOAT: begin
				dec.mnemonic = MN_FLOAT;
				dec.form     = FORM_FLOAT;
			end
			default: begin
				if (op <= OP_BR_LAST) begin
					dec.mnemonic = MN_BR + {4'b0000, op[1:0]};
					dec.form     = FORM_BRANCH;
					dec.target   = pc_s1 + off26;
				end else if (op <= OP_BB_LAST) begin
					dec.mnemonic    = MN_BB0 + {4'b0000, op[1:0]};
					dec.form        = FORM_BITBR;
					dec.cond_or_bit = rd;
					dec.src1_reg    = rs1;
					dec.target      = pc_s1 + off16;
				end else if (op == OP_BCND || op == OP_BCND_N) begin
					dec.mnemonic    = MN_BCND + {5'b00000, op[0]};
					dec.form        = FORM_BITBR;
					dec.cond_or_bit = {2'b00, word_s1[23:21]};
					dec.src1_reg    = rs1;
					dec.target      = pc_s1 + off16;
				end else if (op == OP_BITFLD) begin
					case (bsub)
						SUB_CLR, SUB_SET, SUB_EXT, SUB_EXTU, SUB_MAK, SUB_ROT: begin
							case (bsub)
								SUB_CLR:  dec.mnemonic = MN_CLR;
								SUB_SET:  dec.mnemonic = MN_SET;
								SUB_EXT:  dec.mnemonic = MN_EXT;
								SUB_EXTU: dec.mnemonic = MN_EXTU;
								SUB_MAK:  dec.mnemonic = MN_MAK;
								default:  dec.mnemonic = MN_ROT;
							endcase
							dec.form      = FORM_BITFLD;
							dec.dest_reg  = rd;
							dec.src1_reg  = rs1;
							dec.immediate = (bsub == SUB_ROT) ? {11'd0, word_s1[4:0]}
								: {6'd0, word_s1[9:0]};
						end
						SUB_TB0, SUB_TB1: begin
							dec.mnemonic    = (bsub == SUB_TB0) ? MN_TB0 : MN_TB1;
							dec.form        = FORM_TRAP;
							dec.src1_reg    = rs1;
							dec.immediate   = {7'd0, word_s1[8:0]};
							dec.cond_or_bit = rd;
						end
						SUB_TCND: begin
							dec.mnemonic    = MN_TCND;
							dec.form        = FORM_TRAP;
							dec.src1_reg    = rs1;
							dec.immediate   = {7'd0, word_s1[8:0]};
							dec.cond_or_bit = {2'b00, word_s1[23:21]};
						end
						default: begin
						end
					endcase
				end else if (op == OP_REG) begin
					case (rsel)
						RSEL_MEM: begin
							dec.mnemonic = {2'b00, rsub};
							dec.form     = FORM_RRR;
							dec.dest_reg = rd;
							dec.src1_reg = rs1;
							dec.src2_reg = rs2;
							dec.scaled   = word_s1[5] || (word_s1[3:0] != 4'd0);
						end
						RSEL_ARITH: begin
							dec.mnemonic     = MN_AND + {2'b00, rsub};
							dec.form         = FORM_RRR;
							dec.dest_reg     = rd;
							dec.src1_reg     = rs1;
							dec.src2_reg     = rs2;
							dec.carry_suffix = word_s1[9:8];
						end
						RSEL_BITFLD: begin
							if (rbf <= RBF_LAST) begin
								dec.mnemonic = MN_CLR + {3'b000, rbf};
								dec.form     = FORM_RRR;
								dec.dest_reg = rd;
								dec.src1_reg = rs1;
								dec.src2_reg = rs2;
							end
						end
						default: begin
							if (rsub <= CTRL_JMP_LAST) begin
								dec.mnemonic = MN_JMP + {4'b0000, rsub[1:0]};
								dec.form     = FORM_ONEREG;
								dec.src2_reg = rs2;
							end else if (rsub == CTRL_FF1 || rsub == CTRL_FF0) begin
								dec.mnemonic = MN_FF1 + {5'b00000, rsub[0]};
								dec.form     = FORM_RRR;
								dec.dest_reg = rd;
								dec.src2_reg = rs2;
							end else if (rsub == CTRL_TBND) begin
								dec.mnemonic = MN_TBND;
								dec.form     = FORM_TRAP;
								dec.src1_reg = rs1;
								dec.src2_reg = rs2;
							end else if (rsub == CTRL_RTE) begin
								dec.mnemonic = MN_RTE;
								dec.form     = FORM_NONE;
							end
						end
					endcase
				end else if (op == OP_TBND) begin
					dec.mnemonic  = MN_TBND;
					dec.form      = FORM_TRAP;
					dec.src1_reg  = rs1;
					dec.immediate = word_s1[15:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!hold_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && !hold_s2) begin
			res_s2 <= dec;
		end
	end

	assign out_valid    = valid_s2;
	assign mnemonic     = res_s2.mnemonic;
	assign form         = res_s2.form;
	assign dest_reg     = res_s2.dest_reg;
	assign src1_reg     = res_s2.src1_reg;
	assign src2_reg     = res_s2.src2_reg;
	assign immediate    = res_s2.immediate;
	assign cond_or_bit  = res_s2.cond_or_bit;
	assign target       = res_s2.target;
	assign carry_suffix = res_s2.carry_suffix;
	assign scaled       = res_s2.scaled;

endmodule

FILE: src/rid_checker.sv
// Port-level checks for the instruction decoder, bound to its top level.
// Depends on rid_pkg and risc_instruction_decoder.
module rid_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [rid_pkg::MN_W-1:0]       mnemonic,
	input logic [rid_pkg::FORM_W-1:0]     form,
	input logic [rid_pkg::REG_W-1:0]      dest_reg,
	input logic [rid_pkg::REG_W-1:0]      src1_reg,
	input logic [rid_pkg::REG_W-1:0]      src2_reg,
	input logic [rid_pkg::IMM_W-1:0]      immediate,
	input logic [rid_pkg::REG_W-1:0]      cond_or_bit,
	input logic [rid_pkg::WORD_W-1:0]     target,
	input logic [1:0]                     carry_suffix,
	input logic                           scaled
);
	import rid_pkg::*;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while result side is free");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(mnemonic) && $stable(target)))
		else $error("stalled result changed");

	a_bad_word_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (form == FORM_ILLEGAL || form == FORM_FLOAT)) |->
		(dest_reg == '0 && src1_reg == '0 && src2_reg == '0 && immediate == '0
		 && cond_or_bit == '0 && target == '0 && carry_suffix == '0 && !scaled
		 && (mnemonic == MN_ILLEGAL || mnemonic == MN_FLOAT)))
		else $error("floating or illegal result carries fields");

	a_target_only_branch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && form != FORM_BRANCH && form != FORM_BITBR) |-> (target == '0))
		else $error("target set outside a branch");

	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> ##1 out_valid)
		else $error("accepted transaction produced no result");

endmodule

bind risc_instruction_decoder rid_checker u_rid_checker (.*);
